@@ sv/lnis_pkg.sv @@
// lnis_pkg: shared widths and defaults for the longest non-increasing
// subsequence length block; no dependencies
package lnis_pkg;

    localparam int VAL_W           = 32;
    localparam int LEN_W           = 11;
    localparam int DEFAULT_MAX_LEN = 1024;

endpackage

@@ sv/longest_nonincreasing_subseq_len.sv @@
// longest_nonincreasing_subseq_len: streaming patience-sort length of the
// longest non-increasing subsequence, tails kept in one synchronous ram
// depends on lnis_pkg
//
//  channel   dir  handshake          payload
//  s_        in   s_valid / s_ready  s_value[31:0], s_last
//  m_        out  m_valid / m_ready  m_length[10:0], m_overflow
//
// each item is searched with k tail reads, k at most ceil(log2(n + 1)) with n tails (11
// at n = 1024); the reads are dependent and go one at a time through the single ram read
// port, and the next item is not taken until the search ends
// aresetn is synchronous, active low; the tails ram is not cleared, only entries below
// the tail count are ever read
// s_ready is high only while no item is in search; a last item whose result
// finds the output register full waits there until m_ready frees it
module longest_nonincreasing_subseq_len #(
    parameter int MAX_LEN = lnis_pkg::DEFAULT_MAX_LEN
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [lnis_pkg::VAL_W-1:0] s_value,
    input  logic                       s_last,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [lnis_pkg::LEN_W-1:0] m_length,
    output logic                       m_overflow
);
    import lnis_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_LEN);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_HOLD   = 2'd2;

    logic [VAL_W-1:0] tails_mem [MAX_LEN];

    logic [1:0]       state_reg, state_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic             last_reg, last_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic [CW-1:0]    mid_reg, mid_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [VAL_W-1:0] rd_data_reg;
    logic [CW-1:0]    run_len_reg, run_len_next;
    logic             ovf_reg, ovf_next;
    logic             m_valid_reg, m_valid_next;
    logic [LEN_W-1:0] m_length_reg, m_length_next;
    logic             m_ovf_reg, m_ovf_next;

    logic             rd_en, wr_en;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [CW-1:0]    lo_c, hi_c, mid_c;
    logic             out_free, out_load;
    logic [CW-1:0]    len_upd;
    logic             ovf_upd;
    logic [CW+LEN_W-1:0] len_ext;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        val_next      = val_reg;
        last_next     = last_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        rd_pend_next  = 1'b0;
        run_len_next  = run_len_reg;
        ovf_next      = ovf_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_length_next = m_length_reg;
        m_ovf_next    = m_ovf_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        out_load      = 1'b0;
        len_upd       = run_len_reg;
        ovf_upd       = ovf_reg;

        // narrow the window with the tail read last cycle
        lo_c = lo_reg;
        hi_c = hi_reg;
        if (rd_pend_reg) begin
            if (rd_data_reg < val_reg) begin
                hi_c = mid_reg;
            end else begin
                lo_c = mid_reg + CW'(1);
            end
        end
        mid_c = lo_c + ((hi_c - lo_c) >> 1);

        len_ext = {{LEN_W{1'b0}}, run_len_reg};

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    val_next   = s_value;
                    last_next  = s_last;
                    lo_next    = '0;
                    hi_next    = run_len_reg;
                    mid_next   = run_len_reg >> 1;
                    rd_en      = (run_len_reg != '0);
                    rd_addr    = mid_next[AW-1:0];
                    rd_pend_next = rd_en;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (lo_c < hi_c) begin
                    lo_next      = lo_c;
                    hi_next      = hi_c;
                    mid_next     = mid_c;
                    rd_en        = 1'b1;
                    rd_addr      = mid_c[AW-1:0];
                    rd_pend_next = 1'b1;
                end else begin
                    // lo_c is the first tail smaller than the value
                    wr_en   = (lo_c < CAP);
                    wr_addr = lo_c[AW-1:0];
                    if ((lo_c == run_len_reg) && (run_len_reg < CAP)) begin
                        len_upd = run_len_reg + CW'(1);
                    end
                    if (lo_c == CAP) begin
                        ovf_upd = 1'b1;
                    end
                    run_len_next = len_upd;
                    ovf_next     = ovf_upd;
                    len_ext      = {{LEN_W{1'b0}}, len_upd};
                    if (!last_reg) begin
                        state_next = ST_IDLE;
                    end else if (out_free) begin
                        out_load      = 1'b1;
                        m_valid_next  = 1'b1;
                        m_length_next = len_ext[LEN_W-1:0];
                        m_ovf_next    = ovf_upd;
                        run_len_next  = '0;
                        ovf_next      = 1'b0;
                        state_next    = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_valid_next  = 1'b1;
                    m_length_next = len_ext[LEN_W-1:0];
                    m_ovf_next    = ovf_reg;
                    run_len_next  = '0;
                    ovf_next      = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
            run_len_reg <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            run_len_reg <= run_len_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg      <= val_next;
        last_reg     <= last_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        m_length_reg <= m_length_next;
        m_ovf_reg    <= m_ovf_next;
    end

    // tails ram, one read and one write port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tails_mem[wr_addr] <= val_reg;
        end
        if (rd_en) begin
            rd_data_reg <= tails_mem[rd_addr];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_length   = m_length_reg;
    assign m_overflow = m_ovf_reg;

    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        run_len_reg <= CAP)
        else $error("tail count above store depth");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (run_len_reg == CAP))
        else $error("overflow set while store not full");

    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (run_len_reg == '0) && !ovf_reg && m_valid_reg)
        else $error("sequence state not cleared after result");

    a_read_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (state_reg == ST_SEARCH))
        else $error("pending tail read outside search");

    a_window_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> (lo_reg <= hi_reg) && (hi_reg <= run_len_reg))
        else $error("search window out of order");

endmodule
